/* rtl/gmps_pkg.sv */
package gmps_pkg;

   localparam int MAX_COLS_DEF = 128;
   localparam int MAX_ROWS_DEF = 128;

   localparam int CELL_W     = 16;
   localparam int SUM_W      = 24;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 8;

   localparam int QUEUE_DEPTH = 2;

   localparam logic [CSR_IDX_W-1:0] REG_GRID_ROWS = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] REG_GRID_COLS = CSR_IDX_W'(1);

   // position class of one cell, worked out by the front end
   typedef struct packed {
      logic first_row;
      logic first_col;
      logic last_cell;
   } gmps_flags_type;

endpackage

/* rtl/gmps_ram.sv */
module gmps_ram import gmps_pkg::*; #(
   parameter int WIDTH = SUM_W,
   parameter int DEPTH = MAX_COLS_DEF
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

/* rtl/gmps_front.sv */
module gmps_front import gmps_pkg::*; #(
   parameter int MAX_COLS = MAX_COLS_DEF,
   parameter int MAX_ROWS = MAX_ROWS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_we,
   input  logic [CSR_IDX_W-1:0]        csr_index,
   input  logic [CSR_DATA_W-1:0]       csr_wdata,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic                        q_ready,
   output logic                        q_push,
   output logic [$clog2(MAX_COLS)-1:0] q_col,
   output gmps_flags_type              q_flags
);

   localparam int CW = $clog2(MAX_COLS);
   localparam int RW = $clog2(MAX_ROWS);

   logic [CSR_DATA_W-1:0] rows_ff, rows_in;
   logic [CSR_DATA_W-1:0] cols_ff, cols_in;
   logic [CW-1:0]         col_ff, col_in;
   logic [RW-1:0]         row_ff, row_in;
   logic                  restart;
   logic [CW-1:0]         last_col;
   logic [RW-1:0]         last_row;
   logic                  at_last_col;
   logic                  at_last_row;

   always_comb begin
      rows_in = rows_ff;
      cols_in = cols_ff;
      restart = 1'b0;
      if (csr_we) begin
         unique case (csr_index)
            REG_GRID_ROWS: begin
               rows_in = csr_wdata;
               restart = 1'b1;
            end
            REG_GRID_COLS: begin
               cols_in = csr_wdata;
               restart = 1'b1;
            end
            default: ;
         endcase
      end
   end

   // zero acts as one, anything past the limit acts as the limit
   always_comb begin
      if (cols_ff == '0) begin
         last_col = '0;
      end else if (32'(cols_ff) > 32'(MAX_COLS)) begin
         last_col = CW'(MAX_COLS - 1);
      end else begin
         last_col = CW'(32'(cols_ff) - 32'd1);
      end
      if (rows_ff == '0) begin
         last_row = '0;
      end else if (32'(rows_ff) > 32'(MAX_ROWS)) begin
         last_row = RW'(MAX_ROWS - 1);
      end else begin
         last_row = RW'(32'(rows_ff) - 32'd1);
      end
   end

   assign at_last_col = (col_ff == last_col);
   assign at_last_row = (row_ff == last_row);

   assign req_ready = q_ready;
   assign q_push    = req_valid && q_ready;
   assign q_col     = col_ff;

   always_comb begin
      q_flags.first_row = (row_ff == '0);
      q_flags.first_col = (col_ff == '0);
      q_flags.last_cell = at_last_col && at_last_row;
   end

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (restart) begin
         col_in = '0;
         row_in = '0;
      end else if (q_push) begin
         if (at_last_col) begin
            col_in = '0;
            row_in = at_last_row ? '0 : row_ff + RW'(1);
         end else begin
            col_in = col_ff + CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff <= CSR_DATA_W'(1);
         cols_ff <= CSR_DATA_W'(1);
         col_ff  <= '0;
         row_ff  <= '0;
      end else begin
         rows_ff <= rows_in;
         cols_ff <= cols_in;
         col_ff  <= col_in;
         row_ff  <= row_in;
      end
   end

endmodule

/* rtl/gmps_queue.sv */
module gmps_queue import gmps_pkg::*; #(
   parameter int WIDTH = 8,
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             push_ready,
   input  logic             pop,
   output logic             pop_valid,
   output logic [WIDTH-1:0] pop_data
);

   localparam int PW = $clog2(DEPTH);
   localparam int NW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [NW-1:0]    count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign push_ready = (count_ff != NW'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = slot_ff[rd_ptr_ff];
   assign do_push    = push && push_ready;
   assign do_pop     = pop && pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + NW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - NW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

/* rtl/gmps_back.sv */
module gmps_back import gmps_pkg::*; #(
   parameter int MAX_COLS = MAX_COLS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        q_valid,
   output logic                        q_pop,
   input  logic signed [CELL_W-1:0]    q_value,
   input  logic [$clog2(MAX_COLS)-1:0] q_col,
   input  gmps_flags_type              q_flags,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic signed [SUM_W-1:0]     rsp_path_sum
);

   localparam int CW = $clog2(MAX_COLS);

   logic                     s1_valid_ff, s1_valid_in;
   logic signed [CELL_W-1:0] s1_value_ff;
   logic [CW-1:0]            s1_col_ff;
   gmps_flags_type           s1_flags_ff;
   logic                     fwd_ff, fwd_in;
   logic signed [SUM_W-1:0]  left_ff;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [SUM_W-1:0]  rsp_sum_ff;

   logic                     advance;
   logic                     retire;
   logic [SUM_W-1:0]         above_raw;
   logic signed [SUM_W-1:0]  above;
   logic signed [SUM_W-1:0]  prior;
   logic signed [SUM_W:0]    sum_wide;
   logic signed [SUM_W-1:0]  best;

   // only a finished grid meeting an untaken result holds the pipe
   assign advance = !(s1_valid_ff && s1_flags_ff.last_cell && rsp_valid_ff && !rsp_ready);
   assign retire  = s1_valid_ff && advance;
   assign q_pop   = q_valid && advance;

   gmps_ram #(
      .WIDTH (SUM_W),
      .DEPTH (MAX_COLS)
   ) u_row_store (
      .clock (clock),
      .we    (retire),
      .waddr (s1_col_ff),
      .wdata (best),
      .re    (q_pop),
      .raddr (q_col),
      .rdata (above_raw)
   );

   // same column written back-to-back (single column grid): the store read
   // saw the old word, the fresh one sits in left_ff
   assign above = fwd_ff ? left_ff : $signed(above_raw);

   always_comb begin
      if (s1_flags_ff.first_row && s1_flags_ff.first_col) begin
         prior = '0;
      end else if (s1_flags_ff.first_row) begin
         prior = left_ff;
      end else if (s1_flags_ff.first_col) begin
         prior = above;
      end else begin
         prior = (above > left_ff) ? above : left_ff;
      end
      sum_wide = {prior[SUM_W-1], prior}
               + {{(SUM_W + 1 - CELL_W){s1_value_ff[CELL_W-1]}}, s1_value_ff};
      if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
         best = sum_wide[SUM_W] ? {1'b1, {(SUM_W - 1){1'b0}}}
                                : {1'b0, {(SUM_W - 1){1'b1}}};
      end else begin
         best = sum_wide[SUM_W-1:0];
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      fwd_in      = fwd_ff;
      if (advance) begin
         s1_valid_in = q_valid;
         fwd_in      = q_valid && s1_valid_ff && (s1_col_ff == q_col);
      end
      rsp_valid_in = rsp_valid_ff;
      if (retire && s1_flags_ff.last_cell) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         s1_value_ff <= q_value;
         s1_col_ff   <= q_col;
         s1_flags_ff <= q_flags;
      end
      if (retire) begin
         left_ff <= best;
      end
      if (retire && s1_flags_ff.last_cell) begin
         rsp_sum_ff <= best;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         fwd_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         fwd_ff       <= fwd_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_path_sum = rsp_sum_ff;

endmodule

/* rtl/grid_max_path_sum_core.sv */
// channel  dir  handshake            payload
// req      in   req_valid/req_ready  req_cell_value  (16b signed, row-major cells)
// rsp      out  rsp_valid/rsp_ready  rsp_path_sum    (24b signed, one per grid)
// csr      in   csr_we               csr_index, csr_wdata (write only)
//
// One cell per cycle sustained; a two-word queue sits between the position
// tracker and the row-store pipeline (read stage, then add/compare/write).
// A grid's sum is registered for rsp as its last cell leaves the add/compare/write stage.
// Only a grid that ends while the previous sum is still untaken stalls.
// Synchronous reset clears control only; the row store is never cleared.
module grid_max_path_sum_core import gmps_pkg::*; #(
   parameter int MAX_COLS = MAX_COLS_DEF,
   parameter int MAX_ROWS = MAX_ROWS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_we,
   input  logic [CSR_IDX_W-1:0]     csr_index,
   input  logic [CSR_DATA_W-1:0]    csr_wdata,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic signed [CELL_W-1:0] req_cell_value,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic signed [SUM_W-1:0]  rsp_path_sum
);

   localparam int CW = $clog2(MAX_COLS);
   localparam int FW = $bits(gmps_flags_type);
   localparam int QW = CELL_W + CW + FW;

   logic                     q_ready;
   logic                     q_push;
   logic [CW-1:0]            f_col;
   gmps_flags_type           f_flags;
   logic [QW-1:0]            q_wdata;
   logic                     q_valid;
   logic                     q_pop;
   logic [QW-1:0]            q_rdata;
   logic signed [CELL_W-1:0] b_value;
   logic [CW-1:0]            b_col;
   gmps_flags_type           b_flags;

   gmps_front #(
      .MAX_COLS (MAX_COLS),
      .MAX_ROWS (MAX_ROWS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .q_ready   (q_ready),
      .q_push    (q_push),
      .q_col     (f_col),
      .q_flags   (f_flags)
   );

   assign q_wdata = {req_cell_value, f_col, f_flags};

   gmps_queue #(
      .WIDTH (QW),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_data  (q_wdata),
      .push_ready (q_ready),
      .pop        (q_pop),
      .pop_valid  (q_valid),
      .pop_data   (q_rdata)
   );

   assign b_value = $signed(q_rdata[QW-1 -: CELL_W]);
   assign b_col   = q_rdata[FW + CW - 1 -: CW];
   assign b_flags = gmps_flags_type'(q_rdata[FW-1:0]);

   gmps_back #(
      .MAX_COLS (MAX_COLS)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .q_valid      (q_valid),
      .q_pop        (q_pop),
      .q_value      (b_value),
      .q_col        (b_col),
      .q_flags      (b_flags),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_path_sum (rsp_path_sum)
   );

endmodule

/* dv/grid_max_path_sum_core_test.sv */
module grid_max_path_sum_core_test;
   import gmps_pkg::*;

   localparam int     QUIET_LIMIT = 2000;  // cycles with no word moving on either channel
   localparam int     LONG_HOLD   = 300;   // one long output stall, in cycles
   localparam int     DRAIN_WAIT  = 8;     // extra wait for the pipeline tail once every sum is in
   localparam int     RAND_CELLS  = 1700;
   localparam longint SUM_TOP     = (longint'(1) <<< (SUM_W - 1)) - 1;
   localparam longint SUM_BOTTOM  = -(longint'(1) <<< (SUM_W - 1));

   // indexes that decode to no register
   localparam logic [CSR_IDX_W-1:0] REG_SPARE_A = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] REG_SPARE_B = CSR_IDX_W'(3);

   typedef enum {DRAIN_FULL, DRAIN_COIN, DRAIN_SPARSE, DRAIN_RUNS} drain_mode_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]     csr_index = '0;
   logic [CSR_DATA_W-1:0]    csr_wdata = '0;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   logic signed [CELL_W-1:0] req_cell_value = '0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic signed [SUM_W-1:0]  rsp_path_sum;

   grid_max_path_sum_core uut (
      .clock          (clock),
      .reset          (reset),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_cell_value (req_cell_value),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_path_sum   (rsp_path_sum)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // ---------------------------------------------------------------- predictor
   logic [CSR_DATA_W-1:0]   rows_setting = CSR_DATA_W'(1);
   logic [CSR_DATA_W-1:0]   cols_setting = CSR_DATA_W'(1);
   logic signed [SUM_W-1:0] row_best [MAX_COLS_DEF];
   logic signed [SUM_W-1:0] left_sum = '0;
   int unsigned             cur_row = 0;
   int unsigned             cur_col = 0;

   logic signed [CELL_W-1:0] cell_q [$];
   logic signed [SUM_W-1:0]  sums_due [$];

   int cells_pushed = 0;
   int cells_accepted = 0;
   int sums_seen = 0;
   int csr_writes = 0;
   int input_stalls = 0;
   int faults = 0;
   int quiet = 0;

   function automatic int unsigned grid_extent(input logic [CSR_DATA_W-1:0] setting,
                                               input int unsigned limit);
      int unsigned v;
      v = int'(setting);
      if (v == 0)
         return 1;
      if (v > limit)
         return limit;
      return v;
   endfunction

   function automatic void restart_grid();
      left_sum = '0;
      cur_row = 0;
      cur_col = 0;
   endfunction

   function automatic void apply_csr(input logic [CSR_IDX_W-1:0] idx,
                                     input logic [CSR_DATA_W-1:0] val);
      if (idx == REG_GRID_ROWS) begin
         rows_setting = val;
         restart_grid();
      end else if (idx == REG_GRID_COLS) begin
         cols_setting = val;
         restart_grid();
      end
   endfunction

   // returns 1 when the word closes a grid, with the grid's path sum
   function automatic bit absorb_cell(input logic signed [CELL_W-1:0] value_in,
                                      output logic signed [SUM_W-1:0] sum);
      int unsigned n_rows, n_cols, r, c;
      longint      prior, total;
      n_rows = grid_extent(rows_setting, MAX_ROWS_DEF);
      n_cols = grid_extent(cols_setting, MAX_COLS_DEF);
      r = cur_row;
      c = cur_col;
      if (c >= n_cols)
         c = 0;
      if (r >= n_rows)
         r = 0;
      if (r == 0 && c == 0)
         prior = 0;
      else if (r == 0)
         prior = longint'(left_sum);
      else if (c == 0)
         prior = longint'(row_best[0]);
      else
         prior = (row_best[c] > left_sum) ? longint'(row_best[c]) : longint'(left_sum);
      total = prior + longint'(value_in);
      if (total > SUM_TOP)
         total = SUM_TOP;
      else if (total < SUM_BOTTOM)
         total = SUM_BOTTOM;
      sum = SUM_W'(total);
      row_best[c] = sum;
      left_sum = sum;
      if (r == n_rows - 1 && c == n_cols - 1) begin
         restart_grid();
         return 1'b1;
      end
      c++;
      if (c == n_cols) begin
         c = 0;
         r++;
      end
      cur_col = c;
      cur_row = r;
      return 1'b0;
   endfunction

   task automatic note_fault(input string msg);
      faults++;
      if (faults <= 10)
         $display("mismatch %0d: %s", faults, msg);
   endtask

   // ---------------------------------------------------------------- driver
   bit req_taken = 1'b0;
   int burst_left = 1;
   int gap_left = 0;

   always @(negedge clock) begin : drive_cells
      bit offer;
      offer = 1'b0;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!(req_valid && !req_taken)) begin
         if (gap_left > 0) begin
            gap_left--;
         end else if (cell_q.size() != 0) begin
            req_cell_value <= cell_q.pop_front();
            offer = 1'b1;
            if (burst_left <= 1) begin
               burst_left = $urandom_range(1, 40);
               gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            end else begin
               burst_left--;
            end
         end
         req_valid <= offer;
      end
   end

   // ---------------------------------------------------------------- receiver
   bit             stall_req = 1'b0;
   bit             long_hold_done = 1'b0;
   int             hold_left = 0;
   int             mode_left = 0;
   int             run_left = 0;
   bit             run_on = 1'b1;
   drain_mode_type drain_mode = DRAIN_FULL;

   always @(negedge clock) begin : drain_sums
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if (stall_req && !long_hold_done) begin
         hold_left = LONG_HOLD - 1;
         long_hold_done = 1'b1;
         rsp_ready <= 1'b0;
      end else begin
         if (mode_left == 0) begin
            drain_mode = drain_mode_type'($urandom_range(0, 3));
            mode_left = $urandom_range(40, 250);
         end else begin
            mode_left--;
         end
         case (drain_mode)
            DRAIN_FULL:   rsp_ready <= 1'b1;
            DRAIN_COIN:   rsp_ready <= ($urandom_range(0, 1) == 1);
            DRAIN_SPARSE: rsp_ready <= ($urandom_range(0, 3) == 0);
            default: begin
               if (run_left == 0) begin
                  run_on = !run_on;
                  run_left = $urandom_range(1, 12);
               end else begin
                  run_left--;
               end
               rsp_ready <= run_on;
            end
         endcase
      end
   end

   // ---------------------------------------------------------------- monitor
   always @(posedge clock) begin : watch_ports
      logic signed [SUM_W-1:0] want;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_valid && req_ready;
         if (req_valid && !req_ready)
            input_stalls++;
         if (req_valid && req_ready) begin
            cells_accepted++;
            if (absorb_cell(req_cell_value, want))
               sums_due.push_back(want);
         end
         if (rsp_valid && rsp_ready) begin
            sums_seen++;
            if (sums_due.size() == 0) begin
               note_fault($sformatf("path sum %0d with no grid closed", rsp_path_sum));
            end else begin
               want = sums_due.pop_front();
               if (rsp_path_sum !== want)
                  note_fault($sformatf("path sum expected %0d got %0d", want, rsp_path_sum));
            end
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            quiet = 0;
         else
            quiet++;
         if (quiet >= QUIET_LIMIT) begin
            $display("timeout: no word moved for %0d cycles", quiet);
            $display("Verification failed");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------- stimulus
   function automatic logic signed [CELL_W-1:0] pick_value();
      case ($urandom_range(0, 7))
         0: return {1'b0, {(CELL_W - 1){1'b1}}};
         1: return {1'b1, {(CELL_W - 1){1'b0}}};
         2: return CELL_W'(int'($urandom_range(0, 64)) - 32);
         default: return CELL_W'($urandom);
      endcase
   endfunction

   task automatic queue_one(input logic signed [CELL_W-1:0] v);
      cell_q.push_back(v);
      cells_pushed++;
   endtask

   // wait out every sum, then the pipeline tail of a grid left open
   task automatic settle();
      while (cells_accepted != cells_pushed || sums_due.size() != 0)
         @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input int val);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= CSR_DATA_W'(val);
      apply_csr(idx, CSR_DATA_W'(val));
      csr_writes++;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   initial begin : stimulus
      int rows_set, cols_set, grids, per_grid, count, pick, rand_cells;
      rand_cells = 0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // 1x1 out of reset: every word is a whole grid
      queue_one(16'sh7FFF);
      queue_one(16'sh8000);
      queue_one(16'sh0000);
      queue_one(16'shFFFF);
      settle();

      // 2x3, second row hits a tie between above and left
      write_csr(REG_GRID_ROWS, 2);
      write_csr(REG_GRID_COLS, 3);
      @(posedge clock);
      queue_one(16'sd10);
      queue_one(16'sd20);
      queue_one(16'sd5);
      queue_one(16'sd20);
      queue_one(16'sd0);
      queue_one(16'sd1);
      settle();

      // zero sizes act as one
      write_csr(REG_GRID_ROWS, 0);
      write_csr(REG_GRID_COLS, 0);
      @(posedge clock);
      queue_one(-16'sd7);
      settle();

      // undecoded indexes change nothing
      write_csr(REG_SPARE_A, 255);
      write_csr(REG_SPARE_B, 170);
      @(posedge clock);
      queue_one(16'sh7FFF);
      settle();

      // single row, then single column
      write_csr(REG_GRID_ROWS, 1);
      write_csr(REG_GRID_COLS, 4);
      @(posedge clock);
      repeat (4) queue_one(16'sh8000);
      settle();
      write_csr(REG_GRID_ROWS, 3);
      write_csr(REG_GRID_COLS, 1);
      @(posedge clock);
      queue_one(16'sh7FFF);
      queue_one(16'sh8000);
      queue_one(16'sd100);
      settle();

      // grid cut short by a register write, then a full one
      write_csr(REG_GRID_ROWS, 2);
      write_csr(REG_GRID_COLS, 2);
      @(posedge clock);
      queue_one(16'sd300);
      queue_one(-16'sd50);
      settle();
      write_csr(REG_GRID_COLS, 2);
      @(posedge clock);
      queue_one(-16'sd1);
      queue_one(16'sd2);
      queue_one(-16'sd3);
      queue_one(16'sd4);
      settle();

      while (rand_cells < RAND_CELLS) begin
         pick = $urandom_range(0, 11);
         grids = $urandom_range(1, 8);
         if (!long_hold_done && rand_cells >= 600) begin
            // sums on every word while the receiver holds off
            rows_set = 1;
            cols_set = 1;
            grids = 80;
            stall_req = 1'b1;
         end else if (pick == 0) begin
            rows_set = ($urandom_range(0, 1) == 0) ? 128 : $urandom_range(129, 255);
            cols_set = $urandom_range(0, 2);
            grids = 1;
         end else if (pick == 1) begin
            rows_set = $urandom_range(0, 2);
            cols_set = ($urandom_range(0, 1) == 0) ? 128 : $urandom_range(129, 255);
            grids = 1;
         end else if (pick == 2) begin
            rows_set = $urandom_range(0, 1);
            cols_set = $urandom_range(0, 1);
            grids = $urandom_range(10, 40);
         end else begin
            rows_set = $urandom_range(1, 6);
            cols_set = $urandom_range(1, 6);
         end
         if ($urandom_range(0, 4) == 0)
            write_csr(($urandom_range(0, 1) == 0) ? REG_SPARE_A : REG_SPARE_B,
                      $urandom_range(0, 255));
         write_csr(REG_GRID_ROWS, rows_set);
         write_csr(REG_GRID_COLS, cols_set);
         per_grid = grid_extent(CSR_DATA_W'(rows_set), MAX_ROWS_DEF)
                  * grid_extent(CSR_DATA_W'(cols_set), MAX_COLS_DEF);
         count = per_grid * grids;
         // sometimes leave a grid open for the next write to cut off
         if (!stall_req && per_grid > 1 && $urandom_range(0, 3) == 0)
            count += $urandom_range(1, per_grid - 1);
         @(posedge clock);
         repeat (count) queue_one(pick_value());
         rand_cells += count;
         settle();
         stall_req = 1'b0;
      end

      settle();
      while (sums_due.size() != 0)
         note_fault($sformatf("path sum %0d never came out", sums_due.pop_front()));
      $display("%0d cells in, %0d path sums checked, %0d register writes incl. extremes",
               cells_accepted, sums_seen, csr_writes);
      $display("one %0d-cycle output hold; input held back for %0d cycles in total",
               LONG_HOLD, input_stalls);
      if (faults == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
